// File: rtl/apa_lfb_pkg.sv
// ----------------------------------------------------------------------------
// APA102 LED frame builder package
// Shared codes, constants and the result record used by the frame builder.
// ----------------------------------------------------------------------------
package apa_lfb_pkg;

  // Request actions.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SHOW  = 2'd2,
    ACT_NEXT  = 2'd3
  } action_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NUM_LEDS  = 3'd0;
  localparam logic [2:0] CFG_RED_OFS   = 3'd1;
  localparam logic [2:0] CFG_GREEN_OFS = 3'd2;
  localparam logic [2:0] CFG_BLUE_OFS  = 3'd3;
  localparam logic [2:0] CFG_BRIGHT    = 3'd4;

  // Frame layout.
  localparam int          LANES         = 3;
  localparam int          HEAD_BYTES    = 4;
  localparam int          BYTES_PER_LED = 4;
  localparam int          END_GROUP     = 16;
  localparam logic [7:0]  BYTE_ZERO     = 8'h00;
  localparam logic [7:0]  BYTE_ONES     = 8'hFF;

  // One result record.
  typedef struct packed {
    logic [23:0] read_color;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic        accepted;
    logic        busy;
  } result_t;

endpackage

// File: rtl/apa_lfb_lane_ram.sv
// ----------------------------------------------------------------------------
// Byte-lane RAM
// Single write port with one enable per byte lane, one registered read port.
// ----------------------------------------------------------------------------
module apa_lfb_lane_ram import apa_lfb_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk_i,
  input  logic [LANES-1:0]          wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [LANES-1:0][7:0]     wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [LANES-1:0][7:0]     rd_data_o
);

  logic [LANES-1:0][7:0] mem [DEPTH];
  logic [LANES-1:0][7:0] rd_data_q;

  // Lane-wise write.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (wr_en_i[l]) begin
        mem[wr_addr_i][l] <= wr_data_i[l];
      end
    end
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/apa102_led_frame_builder.sv
// ----------------------------------------------------------------------------
// APA102 LED frame builder
// Pixel store with configurable wire byte order, brightness-scaled frame
// snapshot and byte-by-byte frame output.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   --------  ---------  ---------------------  ----------------------------
//   request   in         in_valid_i/in_stall_o  action_i, led_index_i, color_i
//   result    out        out_valid_o/out_stall_i read_color_o, frame_byte_o,
//                                               frame_last_o, accepted_o,
//                                               busy_res_o
//   config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// A write, a refused request or a start, end or marker byte passes from accept
// through the execute and hand-over states; a read or an LED color byte also
// passes a read state, since the store read is registered. A show walks the
// store through one shared 8x8 multiplier: per LED one read state, then three
// byte scalings, each a multiply state and a write state.
// After reset the pixel store is cleared one entry per cycle, all MAX_LEDS
// entries, during which no request is taken. A finished result waits in the
// output register while a stalled consumer holds it; the next request is
// already taken and its result waits until the output register frees up.
module apa102_led_frame_builder import apa_lfb_pkg::*; #(
  parameter int MAX_LEDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  led_index_i,
  input  logic [23:0] color_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] read_color_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  output logic        accepted_o,
  output logic        busy_res_o,
  // Configuration port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  localparam int AW      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W   = $clog2(MAX_LEDS + 1);
  localparam int MAX_LEN = HEAD_BYTES + BYTES_PER_LED * MAX_LEDS
                           + (MAX_LEDS + END_GROUP - 1) / END_GROUP;
  localparam int POS_W   = $clog2(MAX_LEN);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_BYTE,
    ST_SHOW_RD,
    ST_SHOW_MUL,
    ST_SHOW_WR,
    ST_OUT
  } state_e;

  // Configuration registers.
  logic [10:0] num_leds_q;
  logic [1:0]  red_ofs_q;
  logic [1:0]  green_ofs_q;
  logic [1:0]  blue_ofs_q;
  logic [7:0]  bright_q;

  // Sequencer and frame state.
  state_e          state_q;
  action_e         cmd_act_q;
  logic [9:0]      cmd_idx_q;
  logic [23:0]     cmd_color_q;
  logic [AW-1:0]   clr_q;
  logic            frame_active_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] last_pos_q;
  logic [CNT_W-1:0] frame_leds_q;
  logic [CNT_W-1:0] led_q;
  logic [1:0]      lane_q;
  logic [1:0]      byte_lane_q;
  logic [15:0]     prod_q;
  result_t         pend_q;
  result_t         out_q;
  logic            out_valid_q;

  // RAM ports.
  logic [LANES-1:0]      pix_we;
  logic [AW-1:0]         pix_waddr;
  logic [LANES-1:0][7:0] pix_wdata;
  logic                  pix_re;
  logic [AW-1:0]         pix_raddr;
  logic [LANES-1:0][7:0] pix_rd;
  logic [LANES-1:0]      frm_we;
  logic [LANES-1:0][7:0] frm_wdata;
  logic                  frm_re;
  logic [AW-1:0]         frm_raddr;
  logic [LANES-1:0][7:0] frm_rd;

  // Derived values.
  logic [CNT_W-1:0] n_act;
  logic             idx_ok;
  logic [POS_W-1:0] len_m1;
  logic [LANES-1:0] lane_hit;
  logic [LANES-1:0][7:0] lane_data;
  logic [POS_W-1:0] q_pos;
  logic [POS_W-1:0] led_span;
  logic             in_start;
  logic             in_leds;
  logic [1:0]       lane_j;
  logic [7:0]       byte_imm;
  logic             need_frm_rd;
  logic             at_last;
  logic [7:0]       src_byte;
  logic [7:0]       scaled_byte;

  // Picks the byte at a wire position; position three reads as zero.
  function automatic logic [7:0] lane_pick(logic [LANES-1:0][7:0] data, logic [1:0] ofs);
    logic [7:0] b;
    case (ofs)
      2'd0:    b = data[0];
      2'd1:    b = data[1];
      2'd2:    b = data[2];
      default: b = BYTE_ZERO;
    endcase
    return b;
  endfunction

  // Effective LED count, clamped to the store depth.
  assign n_act  = (32'(num_leds_q) > MAX_LEDS) ? CNT_W'(MAX_LEDS) : CNT_W'(num_leds_q);
  assign idx_ok = 32'(cmd_idx_q) < 32'(n_act);
  assign len_m1 = POS_W'(HEAD_BYTES + 32'(n_act) * BYTES_PER_LED
                         + ((32'(n_act) + END_GROUP - 1) >> 4) - 1);

  // Wire lane enables and data for a pixel write; blue wins over green over red.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_hit[l] = (red_ofs_q == 2'(l)) || (green_ofs_q == 2'(l)) ||
                    (blue_ofs_q == 2'(l));
      if (blue_ofs_q == 2'(l)) begin
        lane_data[l] = cmd_color_q[7:0];
      end else if (green_ofs_q == 2'(l)) begin
        lane_data[l] = cmd_color_q[15:8];
      end else begin
        lane_data[l] = cmd_color_q[23:16];
      end
    end
  end

  // Frame position decode: start bytes, LED groups, end bytes.
  always_comb begin
    q_pos       = pos_q - POS_W'(HEAD_BYTES);
    led_span    = POS_W'({frame_leds_q, 2'b00});
    in_start    = pos_q < POS_W'(HEAD_BYTES);
    in_leds     = !in_start && (q_pos < led_span);
    lane_j      = q_pos[1:0];
    need_frm_rd = in_leds && (lane_j != 2'd0);
    at_last     = pos_q == last_pos_q;
    if (in_start) begin
      byte_imm = BYTE_ZERO;
    end else if (in_leds && (lane_j != 2'd0)) begin
      byte_imm = BYTE_ZERO;
    end else begin
      byte_imm = BYTE_ONES;
    end
  end

  // Show datapath: the shared multiplier scales one byte at a time.
  assign src_byte    = lane_pick(pix_rd, lane_q);
  assign scaled_byte = (bright_q != 8'd0) ? prod_q[15:8] : src_byte;

  // Pixel store port control.
  always_comb begin
    pix_we    = '0;
    pix_waddr = clr_q;
    pix_wdata = '0;
    pix_re    = 1'b0;
    pix_raddr = AW'(led_q);
    if (state_q == ST_CLEAR) begin
      pix_we = '1;
    end else if (state_q == ST_EXEC && cmd_act_q == ACT_WRITE && idx_ok) begin
      pix_we    = lane_hit;
      pix_waddr = AW'(cmd_idx_q);
      pix_wdata = lane_data;
    end
    if (state_q == ST_EXEC && cmd_act_q == ACT_READ && idx_ok) begin
      pix_re    = 1'b1;
      pix_raddr = AW'(cmd_idx_q);
    end else if (state_q == ST_SHOW_RD) begin
      pix_re = 1'b1;
    end
  end

  // Frame store port control.
  always_comb begin
    frm_we    = '0;
    frm_wdata = {LANES{scaled_byte}};
    if (state_q == ST_SHOW_WR) begin
      frm_we = LANES'(1) << lane_q;
    end
    frm_re    = (state_q == ST_EXEC) && (cmd_act_q == ACT_NEXT) && frame_active_q &&
                need_frm_rd;
    frm_raddr = AW'(q_pos >> 2);
  end

  apa_lfb_lane_ram #(
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_pixel_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pix_we),
    .wr_addr_i (pix_waddr),
    .wr_data_i (pix_wdata),
    .rd_en_i   (pix_re),
    .rd_addr_i (pix_raddr),
    .rd_data_o (pix_rd)
  );

  apa_lfb_lane_ram #(
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_frame_ram (
    .clk_i     (clk_i),
    .wr_en_i   (frm_we),
    .wr_addr_i (AW'(led_q)),
    .wr_data_i (frm_wdata),
    .rd_en_i   (frm_re),
    .rd_addr_i (frm_raddr),
    .rd_data_o (frm_rd)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_leds_q  <= '0;
      red_ofs_q   <= 2'd0;
      green_ofs_q <= 2'd1;
      blue_ofs_q  <= 2'd2;
      bright_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_LEDS:  num_leds_q  <= cfg_data_i;
        CFG_RED_OFS:   red_ofs_q   <= cfg_data_i[1:0];
        CFG_GREEN_OFS: green_ofs_q <= cfg_data_i[1:0];
        CFG_BLUE_OFS:  blue_ofs_q  <= cfg_data_i[1:0];
        CFG_BRIGHT:    bright_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer, frame state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      cmd_act_q      <= ACT_WRITE;
      cmd_idx_q      <= '0;
      cmd_color_q    <= '0;
      clr_q          <= '0;
      frame_active_q <= 1'b0;
      pos_q          <= '0;
      last_pos_q     <= '0;
      frame_leds_q   <= '0;
      led_q          <= '0;
      lane_q         <= '0;
      byte_lane_q    <= '0;
      prod_q         <= '0;
      pend_q         <= '0;
      out_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_LEDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_act_q   <= action_e'(action_i);
            cmd_idx_q   <= led_index_i;
            cmd_color_q <= color_i;
            state_q     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          pend_q  <= '0;
          state_q <= ST_OUT;
          case (cmd_act_q)
            ACT_WRITE, ACT_READ: begin
              pend_q.accepted <= idx_ok;
              pend_q.busy     <= frame_active_q;
              if (cmd_act_q == ACT_READ && idx_ok) begin
                state_q <= ST_READ;
              end
            end
            ACT_SHOW: begin
              pend_q.busy <= 1'b1;
              if (!frame_active_q) begin
                pend_q.accepted <= 1'b1;
                frame_active_q  <= 1'b1;
                frame_leds_q    <= n_act;
                last_pos_q      <= len_m1;
                pos_q           <= '0;
                led_q           <= '0;
                lane_q          <= '0;
                if (n_act != '0) begin
                  state_q <= ST_SHOW_RD;
                end
              end
            end
            ACT_NEXT: begin
              if (frame_active_q) begin
                pend_q.frame_byte <= byte_imm;
                pend_q.frame_last <= at_last;
                pend_q.accepted   <= 1'b1;
                pend_q.busy       <= !at_last;
                byte_lane_q       <= lane_j - 2'd1;
                if (at_last) begin
                  frame_active_q <= 1'b0;
                  pos_q          <= '0;
                end else begin
                  pos_q <= pos_q + POS_W'(1);
                end
                if (need_frm_rd) begin
                  state_q <= ST_BYTE;
                end
              end
            end
            default: ;
          endcase
        end
        ST_READ: begin
          pend_q.read_color <= {lane_pick(pix_rd, red_ofs_q),
                                lane_pick(pix_rd, green_ofs_q),
                                lane_pick(pix_rd, blue_ofs_q)};
          state_q <= ST_OUT;
        end
        ST_BYTE: begin
          pend_q.frame_byte <= lane_pick(frm_rd, byte_lane_q);
          state_q           <= ST_OUT;
        end
        ST_SHOW_RD: begin
          state_q <= ST_SHOW_MUL;
        end
        ST_SHOW_MUL: begin
          prod_q  <= 16'(src_byte) * 16'(bright_q);
          state_q <= ST_SHOW_WR;
        end
        ST_SHOW_WR: begin
          if (lane_q == 2'(LANES - 1)) begin
            lane_q <= '0;
            if (led_q == frame_leds_q - CNT_W'(1)) begin
              state_q <= ST_OUT;
            end else begin
              led_q   <= led_q + CNT_W'(1);
              state_q <= ST_SHOW_RD;
            end
          end else begin
            lane_q  <= lane_q + 2'd1;
            state_q <= ST_SHOW_MUL;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Port drive.
  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign read_color_o = out_q.read_color;
  assign frame_byte_o = out_q.frame_byte;
  assign frame_last_o = out_q.frame_last;
  assign accepted_o   = out_q.accepted;
  assign busy_res_o   = out_q.busy;

  // The final byte of a frame always ends it.
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> accepted_o && !busy_res_o)
    else $error("frame_last without a completed frame");

  // The frame position never runs past the latched last byte.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_active_q |-> pos_q <= last_pos_q)
    else $error("frame position beyond frame length");

  // Nonzero data only comes with a request that took effect.
  a_data_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_byte_o != 8'h00 || read_color_o != 24'h0) |-> accepted_o)
    else $error("result data on a refused request");

  // A new result appears only after the sequencer hands it over.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result presented outside the hand-over step");

endmodule
